// ===== rtl/fm_fax_demodulator_unit_defines.svh =====
// assertion helpers for the fax demodulator
`ifndef FM_FAX_DEMODULATOR_UNIT_DEFINES_SVH
`define FM_FAX_DEMODULATOR_UNIT_DEFINES_SVH
// concurrent check, disabled while reset is asserted
`define FFD_ASSERT(lbl, clk_s, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (prop)) else $error(msg);
// concurrent check that also holds during reset
`define FFD_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);
`endif

// ===== rtl/ffd_pkg.sv =====
`timescale 1ns / 1ps
package ffd_pkg;
	localparam int TAPS = 17;
	localparam int PHASE_BITS = 32;
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_GUARD = 8;
	localparam logic signed [15:0] GAIN_RESET = -16'sd4992;
	localparam logic [1:0] REG_PHASE_STEP = 2'd0;
	localparam logic [1:0] REG_FILTER_BAND = 2'd1;
	localparam logic [1:0] REG_DISC_GAIN = 2'd2;

	typedef struct packed {
		logic signed [15:0] i;
		logic signed [15:0] q;
	} mix_t;

	function automatic logic signed [9:0] coef(input logic [1:0] band, input logic [4:0] k);
		logic signed [9:0] c;
		logic [1:0] b;
		logic [4:0] m;
		b = (band == 2'd3) ? 2'd2 : band;
		m = (k > 5'd8) ? 5'(5'd16 - k) : k;
		c = '0;
		case (b)
			2'd0: case (m)
				5'd0: c = -10'sd7; 5'd1: c = -10'sd18; 5'd2: c = -10'sd15;
				5'd3: c = 10'sd11; 5'd4: c = 10'sd56; 5'd5: c = 10'sd116;
				5'd6: c = 10'sd177; 5'd7: c = 10'sd223; default: c = 10'sd240;
			endcase
			2'd1: case (m)
				5'd0: c = 10'sd0; 5'd1: c = -10'sd18; 5'd2: c = -10'sd38;
				5'd3: c = -10'sd39; 5'd4: c = 10'sd0; 5'd5: c = 10'sd83;
				5'd6: c = 10'sd191; 5'd7: c = 10'sd284; default: c = 10'sd320;
			endcase
			default: case (m)
				5'd0: c = 10'sd6; 5'd1: c = 10'sd20; 5'd2: c = 10'sd7;
				5'd3: c = -10'sd42; 5'd4: c = -10'sd74; 5'd5: c = -10'sd12;
				5'd6: c = 10'sd159; 5'd7: c = 10'sd353; default: c = 10'sd440;
			endcase
		endcase
		return c;
	endfunction

	function automatic logic [31:0] atan_turn(input logic [3:0] k);
		logic [31:0] a;
		case (k)
			4'd0: a = 32'h20000000; 4'd1: a = 32'h12E4051E; 4'd2: a = 32'h09FB385B;
			4'd3: a = 32'h051111D4; 4'd4: a = 32'h028B0D43; 4'd5: a = 32'h0145D7E1;
			4'd6: a = 32'h00A2F61E; 4'd7: a = 32'h00517C55; 4'd8: a = 32'h0028BE53;
			4'd9: a = 32'h00145F2F; 4'd10: a = 32'h000A2F98; 4'd11: a = 32'h000517CC;
			4'd12: a = 32'h00028BE6; 4'd13: a = 32'h000145F3; 4'd14: a = 32'h0000A2F9;
			default: a = 32'h0000517C;
		endcase
		return a;
	endfunction
endpackage

// ===== rtl/ffd_stream_if.sv =====
`timescale 1ns / 1ps
interface ffd_stream_if #(parameter int W = 16);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/ffd_front.sv =====
`timescale 1ns / 1ps
`include "fm_fax_demodulator_unit_defines.svh"
// oscillator by iterative cordic and mixer; pushes one mixed pair into the queue
module ffd_front #(
	parameter int PHASE_BITS = ffd_pkg::PHASE_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic [31:0] phase_step,
	ffd_stream_if.sink in_ch,
	output logic push,
	output ffd_pkg::mix_t push_data,
	input logic full
);
	typedef enum logic [1:0] {S_IDLE, S_ROT, S_MIX, S_PUSH} state_t;
	state_t state_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic signed [15:0] smp_q;
	logic signed [25:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic flip_q;
	logic [3:0] k_q;
	logic signed [15:0] c_q, s_q;

	logic [31:0] ang, angf;
	logic signed [25:0] xs, ys;
	logic signed [26:0] xr, yr;
	logic signed [16:0] xc, yc;
	logic signed [32:0] pc, ps;

	function automatic logic signed [15:0] sat17(input logic signed [18:0] v);
		if (v > 19'sd32767) return 16'sd32767;
		if (v < -19'sd32767) return -16'sd32767;
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] sat_mix(input logic signed [32:0] p);
		logic signed [32:0] t;
		t = (p + 33'sd16384) >>> 15;
		if (t > 33'sd32767) return 16'sd32767;
		if (t < -33'sd32768) return -16'sd32768;
		return t[15:0];
	endfunction

	always_comb begin
		ang = 32'(phase_q) << (32 - PHASE_BITS);
		angf = (ang[31] ^ ang[30]) ? ang - 32'h80000000 : ang;
		xs = x_q >>> k_q;
		ys = y_q >>> k_q;
		xr = (27'(x_q) + 27'sd128) >>> 8;
		yr = (27'(y_q) + 27'sd128) >>> 8;
		xc = 17'(sat17(19'(xr)));
		yc = 17'(sat17(19'(yr)));
		if (flip_q) begin
			xc = -xc;
			yc = -yc;
		end
		pc = 33'(smp_q) * 33'(c_q);
		ps = 33'(smp_q) * 33'(s_q);
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign push = (state_q == S_PUSH) && !full;
	assign push_data = {sat_mix(pc), sat_mix(ps)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= '0;
			k_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_ch.valid) begin
					smp_q <= in_ch.data;
					flip_q <= ang[31] ^ ang[30];
					x_q <= 26'sd19897 <<< 8;
					y_q <= '0;
					z_q <= {angf[31], angf};
					k_q <= '0;
					phase_q <= phase_q + phase_step[PHASE_BITS-1:0];
					state_q <= S_ROT;
				end
				S_ROT: begin
					if (!z_q[32]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - 33'(ffd_pkg::atan_turn(k_q));
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + 33'(ffd_pkg::atan_turn(k_q));
					end
					k_q <= k_q + 4'd1;
					if (k_q == 4'(ffd_pkg::CORDIC_STEPS - 1)) state_q <= S_MIX;
				end
				S_MIX: begin
					c_q <= xc[15:0];
					s_q <= yc[15:0];
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (!full) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the mixed pair comes from smp_q, c_q and s_q, which hold through the push state
	`FFD_ASSERT(a_push_state, clk, arst_n, push |-> state_q == S_PUSH, "push outside push state")
	`FFD_ASSERT(a_no_accept_busy, clk, arst_n, state_q != S_IDLE |-> !in_ch.ready, "ready while busy")
	`FFD_ASSERT(a_rot_len, clk, arst_n, $rose(state_q == S_MIX) |-> $past(k_q) == 4'd15, "short rotation")
endmodule

// ===== rtl/ffd_queue.sv =====
`timescale 1ns / 1ps
`include "fm_fax_demodulator_unit_defines.svh"
// two-entry queue between front and back
module ffd_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input ffd_pkg::mix_t wdata,
	output logic full,
	input logic pop,
	output ffd_pkg::mix_t rdata,
	output logic empty
);
	ffd_pkg::mix_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end

	`FFD_ASSERT_ALWAYS(a_cnt_range, clk, cnt_q != 2'd3, "queue count overflow")
	`FFD_ASSERT(a_no_over, clk, arst_n, full |=> cnt_q != 2'd0 || $past(pop), "full queue drained without pop")
	`FFD_ASSERT(a_ptr, clk, arst_n, (cnt_q == 2'd1) |-> (wp_q != rp_q), "pointer mismatch")
endmodule

// ===== rtl/ffd_back.sv =====
`timescale 1ns / 1ps
`include "fm_fax_demodulator_unit_defines.svh"
// fir mac, bit-serial sqrt and divide, discriminator and output register
module ffd_back (
	input logic clk,
	input logic arst_n,
	input logic [1:0] filter_band,
	input logic signed [15:0] disc_gain,
	input logic empty,
	input ffd_pkg::mix_t rdata,
	output logic pop,
	ffd_stream_if.source out_ch
);
	localparam int TAPS = ffd_pkg::TAPS;
	typedef enum logic [3:0] {B_IDLE, B_FIR, B_SQ, B_SQRT, B_DIVI, B_DIVQ, B_X1, B_X2, B_X3,
		B_OUT} state_t;
	state_t state_q;
	logic signed [15:0] id_q [TAPS];
	logic signed [15:0] qd_q [TAPS];
	logic [4:0] slot_q, k_q, idx;
	logic signed [31:0] fi_q, fq_q;
	logic [61:0] sq_q;
	logic [61:0] rem_q;
	logic [30:0] root_q;
	logic [4:0] it_q;
	logic [46:0] dnum_q, drem_q;
	logic [46:0] quo_q;
	logic [5:0] dit_q;
	logic signed [15:0] ni_q, nq_q, pi_q, pq_q;
	logic signed [31:0] xa_q, xb_q;
	logic signed [32:0] cross_q;
	logic signed [48:0] g_q;
	logic [7:0] px_q;
	logic ov_q;

	logic [5:0] isum;
	logic signed [25:0] pi_p, pq_p;
	logic [31:0] ai, aq;
	logic [32:0] trial;
	logic [63:0] rsh;
	logic [47:0] dr;
	logic [31:0] mag;
	logic signed [57:0] nn;
	logic out_load;

	function automatic logic signed [15:0] unit_fin(input logic [46:0] q, input logic neg);
		logic [15:0] c;
		c = (q > 47'd32767) ? 16'd32767 : q[15:0];
		return neg ? -$signed(c) : $signed(c);
	endfunction

	always_comb begin
		isum = 6'(slot_q) + 6'(k_q);
		idx = (isum >= 6'(TAPS)) ? 5'(isum - 6'(TAPS)) : isum[4:0];
		pi_p = 26'(ffd_pkg::coef(filter_band, k_q)) * 26'(id_q[idx]);
		pq_p = 26'(ffd_pkg::coef(filter_band, k_q)) * 26'(qd_q[idx]);
		ai = fi_q[31] ? 32'(-fi_q) : 32'(fi_q);
		aq = fq_q[31] ? 32'(-fq_q) : 32'(fq_q);
		trial = {root_q, 2'b01};
		rsh = {rem_q, sq_q[61:60]};
		mag = {1'b0, root_q};
		dr = {drem_q, dnum_q[46]};
		nn = 58'(g_q) * 58'sd255 + (58'sd255 <<< 40);
	end

	assign pop = (state_q == B_IDLE) && !empty && !(out_ch.valid && !out_ch.ready);
	assign out_load = (state_q == B_OUT) && (!ov_q || out_ch.ready);
	assign out_ch.valid = ov_q;
	assign out_ch.data = px_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			slot_q <= '0;
			k_q <= '0;
			ov_q <= 1'b0;
			pi_q <= '0;
			pq_q <= '0;
			for (int t = 0; t < TAPS; t++) begin
				id_q[t] <= '0;
				qd_q[t] <= '0;
			end
		end else begin
			if (out_load) ov_q <= 1'b1;
			else if (out_ch.ready) ov_q <= 1'b0;
			unique case (state_q)
				B_IDLE: if (pop) begin
					id_q[slot_q] <= rdata.i;
					qd_q[slot_q] <= rdata.q;
					fi_q <= '0;
					fq_q <= '0;
					k_q <= '0;
					state_q <= B_FIR;
				end
				B_FIR: begin
					fi_q <= fi_q + 32'(pi_p);
					fq_q <= fq_q + 32'(pq_p);
					k_q <= k_q + 5'd1;
					if (k_q == 5'(TAPS - 1)) begin
						slot_q <= (slot_q == 5'd0) ? 5'(TAPS - 1) : slot_q - 5'd1;
						state_q <= B_SQ;
					end
				end
				B_SQ: begin
					sq_q <= 62'(ai) * 62'(ai) + 62'(aq) * 62'(aq);
					rem_q <= '0;
					root_q <= '0;
					it_q <= '0;
					state_q <= B_SQRT;
				end
				B_SQRT: begin
					sq_q <= sq_q << 2;
					if (rsh >= 64'(trial)) begin
						rem_q <= 62'(rsh - 64'(trial));
						root_q <= {root_q[29:0], 1'b1};
					end else begin
						rem_q <= rsh[61:0];
						root_q <= {root_q[29:0], 1'b0};
					end
					it_q <= it_q + 5'd1;
					if (it_q == 5'd30) begin
						// root before its last bit is half the final root
						dnum_q <= 47'(ai) * 47'd32768 + 47'(root_q);
						drem_q <= '0;
						dit_q <= '0;
						state_q <= B_DIVI;
					end
				end
				B_DIVI, B_DIVQ: begin
					if (mag == 32'd0) begin
						ni_q <= '0;
						nq_q <= '0;
						state_q <= B_X1;
					end else if (dit_q == 6'd46) begin
						dit_q <= '0;
						drem_q <= '0;
						if (state_q == B_DIVI) begin
							ni_q <= unit_fin({quo_q[45:0], dr >= 48'(mag)}, fi_q[31]);
							dnum_q <= 47'(aq) * 47'd32768 + 47'(mag >> 1);
							state_q <= B_DIVQ;
						end else begin
							nq_q <= unit_fin({quo_q[45:0], dr >= 48'(mag)}, fq_q[31]);
							state_q <= B_X1;
						end
					end else begin
						dnum_q <= dnum_q << 1;
						if (dr >= 48'(mag)) begin
							drem_q <= 47'(dr - 48'(mag));
							quo_q <= {quo_q[45:0], 1'b1};
						end else begin
							drem_q <= dr[46:0];
							quo_q <= {quo_q[45:0], 1'b0};
						end
						dit_q <= dit_q + 6'd1;
					end
				end
				B_X1: begin
					xa_q <= 32'(nq_q) * 32'(pi_q);
					xb_q <= 32'(ni_q) * 32'(pq_q);
					state_q <= B_X2;
				end
				B_X2: begin
					cross_q <= 33'(xa_q) - 33'(xb_q);
					pi_q <= ni_q;
					pq_q <= nq_q;
					state_q <= B_X3;
				end
				B_X3: begin
					g_q <= 49'(cross_q) * 49'(disc_gain);
					state_q <= B_OUT;
				end
				B_OUT: if (out_load) begin
					if (nn < 0) px_q <= 8'd0;
					else if ((nn >>> 41) > 58'sd255) px_q <= 8'd255;
					else px_q <= nn[48:41];
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	`FFD_ASSERT(a_pop_idle, clk, arst_n, pop |-> state_q == B_IDLE, "pop while busy")
	`FFD_ASSERT(a_fir_len, clk, arst_n, $rose(state_q == B_SQ) |-> $past(k_q) == 5'd16, "short fir")
	`FFD_ASSERT(a_out_hold, clk, arst_n, (out_ch.valid && !out_ch.ready) |=> out_ch.valid, "result lost")
endmodule

// ===== rtl/fm_fax_demodulator_unit.sv =====
`timescale 1ns / 1ps
// fm fax demodulator: one signed 16-bit audio sample in, one 8-bit pixel out
// input channel sample_in carries sample; output channel pixel_out carries pixel
// a transfer happens at a rising edge with valid and ready both high
// configuration over apb: 0x0 phase_step, 0x4 filter_band, 0x8 disc_gain;
// write only while idle; reads return register values; pready is tied high
// front: 16-step cordic oscillator plus mixer; it takes no new sample until the last is pushed
// back: 17-tap fir mac, 31-step square root and two 47-step divides,
// discriminator states x1, x2, x3 and an output state; it pops the queue only when idle
// a two-entry queue between them lets either side stall on its own
// the back, chiefly its serial divider, sets the sustained rate
// reset clears oscillator phase, delay lines, previous vector and registers
// when the receiver stalls the pixel is held in the output register, the back
// waits there and the front keeps filling the queue until it is full
module fm_fax_demodulator_unit #(
	parameter int PHASE_BITS = ffd_pkg::PHASE_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	ffd_stream_if.sink sample_in,
	ffd_stream_if.source pixel_out
);
	logic [31:0] phase_step_q;
	logic [1:0] filter_band_q;
	logic signed [15:0] disc_gain_q;
	logic [1:0] reg_idx;
	logic push, full, pop, empty;
	ffd_pkg::mix_t wdata, rdata;

	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];

	// register write on access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			filter_band_q <= '0;
			disc_gain_q <= ffd_pkg::GAIN_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				ffd_pkg::REG_PHASE_STEP: phase_step_q <= pwdata;
				ffd_pkg::REG_FILTER_BAND: filter_band_q <= pwdata[1:0];
				ffd_pkg::REG_DISC_GAIN: disc_gain_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ffd_pkg::REG_PHASE_STEP: prdata = phase_step_q;
			ffd_pkg::REG_FILTER_BAND: prdata = {30'd0, filter_band_q};
			ffd_pkg::REG_DISC_GAIN: prdata = {{16{disc_gain_q[15]}}, disc_gain_q};
			default: prdata = '0;
		endcase
	end

	ffd_front #(.PHASE_BITS(PHASE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .phase_step(phase_step_q), .in_ch(sample_in),
		.push(push), .push_data(wdata), .full(full)
	);

	ffd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(wdata), .full(full),
		.pop(pop), .rdata(rdata), .empty(empty)
	);

	ffd_back u_back (
		.clk(clk), .arst_n(arst_n), .filter_band(filter_band_q), .disc_gain(disc_gain_q),
		.empty(empty), .rdata(rdata), .pop(pop), .out_ch(pixel_out)
	);
endmodule
